// ===== hdl/apq_pkg.sv =====
`timescale 1ns / 1ps

package apq_pkg;

	localparam int DEPTH_DEF          = 8;
	localparam int DATA_WIDTH_DEF     = 32;
	localparam int PRIORITY_WIDTH_DEF = 16;
	localparam int CAP_WIDTH          = 4;
	localparam logic [CAP_WIDTH-1:0] CAP_RESET = 4'd8;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_PULL   = 2'd1,
		OP_PEEK   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_WAIT,
		S_PICK,
		S_SHIFT,
		S_SHIFT_WAIT,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic do_insert;
		logic set_done;
		logic set_empty;
		logic scan_start;
		logic scan_rd;
		logic pick;
		logic shift_start;
		logic shift_rd;
		logic dec_count;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic idx_last;
		logic best_last;
		logic out_busy;
	} sts_t;

endpackage

// ===== hdl/apq_ctrl.sv =====
`timescale 1ns / 1ps

module apq_ctrl
	import apq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] operation,
	input  sts_t       sts,
	output cmd_t       cmd,
	output state_t     state
);

	state_t state_q;
	state_t state_d;
	logic   pull_q;
	logic   accept;
	op_t    op;

	assign op       = op_t'(operation);
	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign state    = state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pull_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				pull_q <= (op == OP_PULL);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (op)
						OP_PULL, OP_PEEK: state_d = sts.empty ? S_RESULT : S_SCAN;
						OP_INSERT, OP_NOP: state_d = S_RESULT;
					endcase
				end
			end
			S_SCAN: begin
				if (sts.idx_last) begin
					state_d = S_SCAN_WAIT;
				end
			end
			S_SCAN_WAIT: state_d = S_PICK;
			S_PICK: begin
				if (pull_q && !sts.best_last) begin
					state_d = S_SHIFT;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_SHIFT: begin
				if (sts.idx_last) begin
					state_d = S_SHIFT_WAIT;
				end
			end
			S_SHIFT_WAIT: state_d = S_RESULT;
			S_RESULT: begin
				if (!sts.out_busy) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (op)
						OP_INSERT: cmd.do_insert = 1'b1;
						OP_NOP:    cmd.set_done  = 1'b1;
						OP_PULL, OP_PEEK: begin
							cmd.set_empty  = sts.empty;
							cmd.scan_start = !sts.empty;
						end
					endcase
				end
			end
			S_SCAN:      cmd.scan_rd = 1'b1;
			S_SCAN_WAIT: cmd = '0;
			S_PICK: begin
				cmd.pick        = 1'b1;
				cmd.dec_count   = pull_q && sts.best_last;
				cmd.shift_start = pull_q && !sts.best_last;
			end
			S_SHIFT:      cmd.shift_rd  = 1'b1;
			S_SHIFT_WAIT: cmd.dec_count = 1'b1;
			S_RESULT:     cmd.load_out  = !sts.out_busy;
			default:      cmd = '0;
		endcase
	end

endmodule

// ===== hdl/apq_dpath.sv =====
`timescale 1ns / 1ps

module apq_dpath
	import apq_pkg::*;
#(
	parameter int DEPTH          = DEPTH_DEF,
	parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
	parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cmd_t                             cmd,
	output sts_t                             sts,
	input  logic                             cfg_we,
	input  logic [CAP_WIDTH-1:0]             cfg_wdata,
	input  logic [DATA_WIDTH-1:0]            item_value,
	input  logic signed [PRIORITY_WIDTH-1:0] item_priority,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [DATA_WIDTH-1:0]            out_value,
	output logic [1:0]                       status,
	output logic                             now_empty,
	output logic                             now_full
);

	localparam int IW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > CAP_WIDTH) ? CW : CAP_WIDTH;

	logic [DATA_WIDTH-1:0]            value_mem [DEPTH];
	logic signed [PRIORITY_WIDTH-1:0] pri_mem   [DEPTH];

	logic [CAP_WIDTH-1:0]             cap_q;
	logic [CW-1:0]                    count_q;
	logic [IW-1:0]                    idx_q;

	logic [DATA_WIDTH-1:0]            rd_val_s1;
	logic signed [PRIORITY_WIDTH-1:0] rd_pri_s1;
	logic [IW-1:0]                    rd_idx_s1;
	logic                             rd_vld_s1;
	logic                             rd_shift_s1;

	logic [DATA_WIDTH-1:0]            best_val_q;
	logic signed [PRIORITY_WIDTH-1:0] best_pri_q;
	logic [IW-1:0]                    best_idx_q;

	logic [DATA_WIDTH-1:0]            res_value_q;
	status_t                          res_status_q;

	logic                             out_valid_q;
	logic [DATA_WIDTH-1:0]            out_value_q;
	status_t                          out_status_q;
	logic                             out_empty_q;
	logic                             out_full_q;

	logic                             full;
	logic                             rd_en;
	logic                             wr_shift;
	logic                             better;

	assign full = (CMPW'(count_q) >= CMPW'(cap_q)) || (count_q == CW'(DEPTH));
	assign rd_en    = cmd.scan_rd || cmd.shift_rd;
	assign wr_shift = rd_vld_s1 && rd_shift_s1;
	assign better   = (rd_idx_s1 == '0) || (rd_pri_s1 > best_pri_q);

	assign sts.empty     = (count_q == '0);
	assign sts.idx_last  = ((CW'(idx_q) + CW'(1)) == count_q);
	assign sts.best_last = ((CW'(best_idx_q) + CW'(1)) == count_q);
	assign sts.out_busy  = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign status    = out_status_q;
	assign now_empty = out_empty_q;
	assign now_full  = out_full_q;

	always_ff @(posedge clk) begin
		if (cmd.do_insert && !full) begin
			value_mem[count_q[IW-1:0]] <= item_value;
			pri_mem[count_q[IW-1:0]]   <= item_priority;
		end else if (wr_shift) begin
			value_mem[rd_idx_s1 - IW'(1)] <= rd_val_s1;
			pri_mem[rd_idx_s1 - IW'(1)]   <= rd_pri_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_val_s1 <= value_mem[idx_q];
			rd_pri_s1 <= pri_mem[idx_q];
			rd_idx_s1 <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			rd_vld_s1   <= 1'b0;
			rd_shift_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			priority if (cmd.do_insert && !full) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.dec_count) begin
				count_q <= count_q - CW'(1);
			end
			rd_vld_s1   <= rd_en;
			rd_shift_s1 <= cmd.shift_rd;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.scan_start) begin
			idx_q <= '0;
		end else if (cmd.shift_start) begin
			idx_q <= best_idx_q + IW'(1);
		end else if (rd_en) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && !rd_shift_s1 && better) begin
			best_val_q <= rd_val_s1;
			best_pri_q <= rd_pri_s1;
			best_idx_q <= rd_idx_s1;
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.do_insert) begin
			res_value_q  <= '0;
			res_status_q <= full ? ST_FULL : ST_DONE;
		end else if (cmd.set_empty) begin
			res_value_q  <= '0;
			res_status_q <= ST_EMPTY;
		end else if (cmd.set_done) begin
			res_value_q  <= '0;
			res_status_q <= ST_DONE;
		end else if (cmd.pick) begin
			res_value_q  <= best_val_q;
			res_status_q <= ST_DONE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
			out_empty_q  <= (count_q == '0);
			out_full_q   <= full;
		end
	end

endmodule

// ===== hdl/array_priority_queue.sv =====
`timescale 1ns / 1ps
// Insert, no-op and a pull or peek on an empty queue go straight to the result state.
// A peek, or a pull of the last entry, scans all N entries for the best one; a pull of
// any earlier entry k then shifts entries k + 1 to N - 1 down one slot. Throughput:
// one transaction at a time; the entry memory read port bounds the scan and the shift to
// one entry per cycle. The next input is taken while the previous result waits in the
// output register. Reset clears the count and sets capacity to 8.
module array_priority_queue
	import apq_pkg::*;
#(
	parameter int DEPTH          = DEPTH_DEF,
	parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
	parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [CAP_WIDTH-1:0]             cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       operation,
	input  logic [DATA_WIDTH-1:0]            item_value,
	input  logic signed [PRIORITY_WIDTH-1:0] item_priority,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [DATA_WIDTH-1:0]            out_value,
	output logic [1:0]                       status,
	output logic                             now_empty,
	output logic                             now_full
);

	cmd_t   cmd;
	sts_t   sts;
	state_t state;

	apq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd),
		.state     (state)
	);

	apq_dpath #(
		.DEPTH          (DEPTH),
		.DATA_WIDTH     (DATA_WIDTH),
		.PRIORITY_WIDTH (PRIORITY_WIDTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.item_value    (item_value),
		.item_priority (item_priority),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_value     (out_value),
		.status        (status),
		.now_empty     (now_empty),
		.now_full      (now_full)
	);

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> now_empty)
		else $error("empty status without empty flag");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> now_full)
		else $error("full status without full flag");

	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_DONE) |-> (out_value == '0))
		else $error("nonzero value on refused transaction");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state == S_RESULT && !(out_valid && out_stall)) |=> (out_valid && state == S_IDLE))
		else $error("result not loaded");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import apq_pkg::*;

	localparam int SLOTS       = DEPTH_DEF;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		logic [DATA_WIDTH_DEF-1:0] value;
		status_t                   stat;
		logic                      empty;
		logic                      full;
	} queue_result_t;

	logic                               clk           = 1'b0;
	logic                               arst_n        = 1'b0;
	logic                               cfg_we        = 1'b0;
	logic [CAP_WIDTH-1:0]               cfg_wdata     = '0;
	logic                               in_valid      = 1'b0;
	logic                               in_stall;
	op_t                                op_drv        = OP_NOP;
	logic [DATA_WIDTH_DEF-1:0]          item_value    = '0;
	logic signed [PRIORITY_WIDTH_DEF-1:0] item_priority = '0;
	logic                               out_valid;
	logic                               out_stall     = 1'b0;
	logic [DATA_WIDTH_DEF-1:0]          out_value;
	logic [1:0]                         status;
	logic                               now_empty;
	logic                               now_full;

	logic [DATA_WIDTH_DEF-1:0]            held_value [SLOTS];
	logic signed [PRIORITY_WIDTH_DEF-1:0] held_priority [SLOTS];
	int                                   held_count    = 0;
	int                                   capacity_reg  = int'(CAP_RESET);
	queue_result_t                        expected_results[$];

	int send_idle_pct  = 6;
	int recv_idle_pct  = 70;
	int errors         = 0;
	int idle_cycles    = 0;
	int items_sent     = 0;
	int results_seen   = 0;
	int refused_count  = 0;
	int empty_count    = 0;
	int served_count   = 0;
	int capacity_writes = 0;

	array_priority_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (op_drv),
		.item_value   (item_value),
		.item_priority(item_priority),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_value    (out_value),
		.status       (status),
		.now_empty    (now_empty),
		.now_full     (now_full)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	function automatic int effective_capacity();
		return (capacity_reg > SLOTS) ? SLOTS : capacity_reg;
	endfunction

	task automatic predict_queue_op(input op_t op, input logic [DATA_WIDTH_DEF-1:0] val,
			input logic signed [PRIORITY_WIDTH_DEF-1:0] pri);
		queue_result_t r;
		int best;
		r.value = '0;
		r.stat  = ST_DONE;
		if (op == OP_INSERT) begin
			if (held_count >= effective_capacity() || held_count >= SLOTS) begin
				r.stat = ST_FULL;
				refused_count++;
			end else begin
				held_value[held_count]    = val;
				held_priority[held_count] = pri;
				held_count++;
			end
		end else if (op == OP_PULL || op == OP_PEEK) begin
			if (held_count == 0) begin
				r.stat = ST_EMPTY;
				empty_count++;
			end else begin
				best = 0;
				for (int i = 1; i < held_count; i++)
					if (held_priority[i] > held_priority[best])
						best = i;
				r.value = held_value[best];
				served_count++;
				if (op == OP_PULL) begin
					for (int i = best; i + 1 < held_count; i++) begin
						held_value[i]    = held_value[i + 1];
						held_priority[i] = held_priority[i + 1];
					end
					held_count--;
				end
			end
		end
		r.empty = (held_count == 0);
		r.full  = (held_count >= effective_capacity());
		expected_results.push_back(r);
	endtask

	task automatic send_item(input op_t op, input logic [DATA_WIDTH_DEF-1:0] val,
			input logic signed [PRIORITY_WIDTH_DEF-1:0] pri);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		op_drv        <= op;
		item_value    <= val;
		item_priority <= pri;
		do @(posedge clk); while (in_stall);
		predict_queue_op(op, val, pri);
		items_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input int cap);
		drain_results();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap[CAP_WIDTH-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		capacity_reg = cap & 'hF;
		capacity_writes++;
	endtask

	always @(posedge clk) begin
		queue_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result value=%h status=%0d", $time, out_value, status);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (out_value !== e.value) begin
					$display("%0t: out_value expected %h actual %h", $time, e.value, out_value);
					errors++;
				end
				if (status !== e.stat) begin
					$display("%0t: status expected %0d actual %0d", $time, e.stat, status);
					errors++;
				end
				if (now_empty !== e.empty) begin
					$display("%0t: now_empty expected %0d actual %0d", $time, e.empty, now_empty);
					errors++;
				end
				if (now_full !== e.full) begin
					$display("%0t: now_full expected %0d actual %0d", $time, e.full, now_full);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic test_empty_queue();
		send_item(OP_PULL, 32'h1234_5678, 16'sd5);
		send_item(OP_PEEK, 32'hFFFF_FFFF, -16'sd1);
		send_item(OP_NOP, 32'hDEAD_BEEF, 16'sd0);
	endtask

	task automatic test_priority_order();
		send_item(OP_INSERT, 32'h0000_0000, 16'sh8000);
		send_item(OP_INSERT, 32'hFFFF_FFFF, 16'sh7FFF);
		send_item(OP_INSERT, 32'h5555_5555, 16'sh7FFF);
		send_item(OP_INSERT, 32'hAAAA_AAAA, 16'sh0000);
		send_item(OP_PEEK, 32'h0, 16'sh0);
		send_item(OP_PULL, 32'h0, 16'sh0);
		send_item(OP_PULL, 32'h0, 16'sh0);
		send_item(OP_PULL, 32'h0, 16'sh0);
		send_item(OP_PULL, 32'h0, 16'sh0);
	endtask

	task automatic test_capacity_limits();
		write_capacity(1);
		send_item(OP_INSERT, 32'h0F0F_0F0F, 16'sd100);
		send_item(OP_INSERT, 32'hF0F0_F0F0, 16'sd200);
		write_capacity(0);
		send_item(OP_INSERT, 32'h1111_1111, 16'sd1);
		send_item(OP_PULL, 32'h0, 16'sh0);
		write_capacity(15);
		send_item(OP_INSERT, 32'h8000_0001, -16'sd2);
		send_item(OP_PEEK, 32'h0, 16'sh0);
		send_item(OP_PULL, 32'h0, 16'sh0);
	endtask

	task automatic test_random_mix();
		int caps [10] = '{15, 8, 1, 3, 0, 12, 2, 8, 15, 5};
		int roll;
		op_t op;
		logic signed [PRIORITY_WIDTH_DEF-1:0] pri;
		for (int c = 0; c < 10; c++) begin
			if (c == 0) begin
				send_idle_pct = 6;
				recv_idle_pct = 70;
			end else if (c == 4) begin
				send_idle_pct = 70;
				recv_idle_pct = 6;
			end else if (c == 7) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_capacity(caps[c]);
			for (int n = 0; n < 95; n++) begin
				roll = $urandom_range(99);
				if (roll < ((n < 48) ? 60 : 35))
					op = OP_INSERT;
				else if (roll < 80)
					op = OP_PULL;
				else if (roll < 95)
					op = OP_PEEK;
				else
					op = OP_NOP;
				roll = $urandom_range(9);
				if (roll < 5)
					pri = PRIORITY_WIDTH_DEF'($urandom_range(6)) - 16'sd3;
				else if (roll < 7)
					pri = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
				else
					pri = PRIORITY_WIDTH_DEF'($urandom);
				send_item(op, $urandom, pri);
				if (c == 5 && n == 47)
					drain_results();
				if (c == 8 && n == 47)
					write_capacity(2);
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_empty_queue();
		test_priority_order();
		test_capacity_limits();
		test_random_mix();
		drain_results();
		repeat (30) @(posedge clk);
		$display("Ran %0d transactions, %0d results: %0d served, %0d refused as full, %0d on empty.",
			items_sent, results_seen, served_count, refused_count, empty_count);
		$display("Capacity rewritten %0d times across 0..15, under three stall profiles.",
			capacity_writes);
		if (errors == 0 && expected_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
